// ===== sv/sst_pkg.sv =====
// shared types and constants for the subscriber lease table
// used by every module of the block; depends on nothing

package sst_pkg;

    // header sizes and register map
    localparam logic [6:0] MIN_HEADER_LEN = 7'd6;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL_VER    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUBSCRIBE_CODE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_REQ_CODE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_MIN_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEASE_TIME      = 3'd5;

    // verdict codes
    localparam logic [2:0] VERDICT_SHORT       = 3'd0;
    localparam logic [2:0] VERDICT_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] VERDICT_BAD_VERSION = 3'd2;
    localparam logic [2:0] VERDICT_UNKNOWN     = 3'd3;
    localparam logic [2:0] VERDICT_NEW         = 3'd4;
    localparam logic [2:0] VERDICT_REFRESHED   = 3'd5;
    localparam logic [2:0] VERDICT_TABLE_FULL  = 3'd6;
    localparam logic [2:0] VERDICT_SYNC_SHORT  = 3'd7;

    // input operations and result kinds
    localparam logic OP_DGRAM     = 1'b0;
    localparam logic OP_FRAME     = 1'b1;
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_DEST    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CHECK,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  protocol_version;
        logic [7:0]  subscribe_code;
        logic [7:0]  sync_request_code;
        logic [6:0]  sync_min_length;
        logic [31:0] lease_time_us;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic [6:0]  dgram_length;
        logic [31:0] hdr_magic;
        logic [7:0]  hdr_version;
        logic [7:0]  hdr_type;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [63:0] now_us;
        logic [63:0] sync_t1;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  verdict;
        logic        sync_reply;
        logic [63:0] echo_t1;
        logic [63:0] reply_time;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [63:0] frame_number;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [63:0] expiry;
    } slot_t;

endpackage

// ===== sv/sst_cfg_regs.sv =====
// configuration register file for the subscriber lease table
// depends on sst_pkg for the register map and cfg_t

module sst_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [sst_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [31:0]                        wr_data,
    output sst_pkg::cfg_t                      cfg
);

    sst_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word        <= 32'd0;
            cfg_reg.protocol_version  <= 8'd1;
            cfg_reg.subscribe_code    <= 8'd1;
            cfg_reg.sync_request_code <= 8'd2;
            cfg_reg.sync_min_length   <= 7'd16;
            cfg_reg.lease_time_us     <= 32'd5000000;
        end else if (wr_en) begin
            case (wr_index)
                sst_pkg::CFG_MAGIC_WORD:      cfg_reg.magic_word        <= wr_data;
                sst_pkg::CFG_PROTOCOL_VER:    cfg_reg.protocol_version  <= wr_data[7:0];
                sst_pkg::CFG_SUBSCRIBE_CODE:  cfg_reg.subscribe_code    <= wr_data[7:0];
                sst_pkg::CFG_SYNC_REQ_CODE:   cfg_reg.sync_request_code <= wr_data[7:0];
                sst_pkg::CFG_SYNC_MIN_LENGTH: cfg_reg.sync_min_length   <= wr_data[6:0];
                sst_pkg::CFG_LEASE_TIME:      cfg_reg.lease_time_us     <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/sst_slot_mem.sv =====
// slot table memory: one write port, one read port, registered read data
// per-entry valid bits make unwritten slots read as empty; depends on sst_pkg

module sst_slot_mem #(
    parameter int SLOTS = 4,
    parameter int IDX_W = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  sst_pkg::slot_t    wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output sst_pkg::slot_t    rd_data
);

    sst_pkg::slot_t mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    sst_pkg::slot_t rd_data_reg;

    // storage array
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    // written-entry flags, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // registered read, empty slot for never-written entries
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_idx] ? mem[rd_idx] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/subscriber_ttl_table.sv =====
// subscriber lease table: a datagram with a bad header goes from decode straight to its verdict;
// a subscribe, sync request or frame fan-out walks the slot memory, reading then checking each slot
// (one read port, registered read data); an item also stays in the block while a result word
// waits on a stalled output register.
// one item is worked at a time; a result waits in the output register without blocking accept.
// reset is synchronous: registers take their reset values and slot valid bits clear at once.

module subscriber_ttl_table #(
    parameter int SLOTS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sst_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sst_pkg::out_t                   m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    sst_pkg::cfg_t   cfg;
    sst_pkg::state_t state_reg, state_next;
    sst_pkg::in_t    item_reg;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [2:0]       verdict_reg, verdict_next;
    logic             reply_reg, reply_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [31:0]      pend_addr_reg, pend_addr_next;
    logic [15:0]      pend_port_reg, pend_port_next;
    logic [63:0]      frame_cnt_reg, frame_cnt_next;
    logic             out_valid_reg;
    sst_pkg::out_t    out_data_reg;

    logic             rd_en, wr_en;
    logic [IDX_W-1:0] wr_idx;
    sst_pkg::slot_t   rd_data, wr_data;
    logic             push;
    sst_pkg::out_t    push_data;
    logic             can_push;
    logic             slot_live, slot_match, last_slot;
    logic [IDX_W-1:0] free_cand;
    logic [64:0]      lease_sum;
    logic [63:0]      lease_end;
    logic             dec_scan, dec_reply;
    logic [2:0]       dec_verdict;

    // configuration registers
    assign cfg_ready = 1'b1;

    sst_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // slot table
    sst_slot_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (idx_reg),
        .rd_data (rd_data)
    );

    // header checks on the held datagram
    always_comb begin
        dec_scan    = 1'b0;
        dec_reply   = 1'b0;
        dec_verdict = sst_pkg::VERDICT_SHORT;
        if (item_reg.dgram_length < sst_pkg::MIN_HEADER_LEN) begin
            dec_verdict = sst_pkg::VERDICT_SHORT;
        end else if (item_reg.hdr_magic != cfg.magic_word) begin
            dec_verdict = sst_pkg::VERDICT_BAD_MAGIC;
        end else if (item_reg.hdr_version != cfg.protocol_version) begin
            dec_verdict = sst_pkg::VERDICT_BAD_VERSION;
        end else if (item_reg.hdr_type == cfg.subscribe_code) begin
            dec_scan = 1'b1;
        end else if (item_reg.hdr_type == cfg.sync_request_code) begin
            if (item_reg.dgram_length < cfg.sync_min_length) begin
                dec_verdict = sst_pkg::VERDICT_SYNC_SHORT;
            end else begin
                dec_scan  = 1'b1;
                dec_reply = 1'b1;
            end
        end else begin
            dec_verdict = sst_pkg::VERDICT_UNKNOWN;
        end
    end

    // slot checks and lease end with saturation
    assign slot_live  = (rd_data.expiry != '0) && (item_reg.now_us < rd_data.expiry);
    assign slot_match = slot_live && (rd_data.addr == item_reg.src_addr)
                        && (rd_data.port == item_reg.src_port);
    assign last_slot  = (idx_reg == LAST_IDX);
    assign free_cand  = free_found_reg ? free_idx_reg : idx_reg;
    assign lease_sum  = {1'b0, item_reg.now_us} + 65'(cfg.lease_time_us);
    assign lease_end  = lease_sum[64] ? '1 : lease_sum[63:0];
    assign wr_data    = '{addr: item_reg.src_addr, port: item_reg.src_port, expiry: lease_end};
    assign can_push   = !out_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sst_pkg::ST_DECODE;
                end
            end
            sst_pkg::ST_DECODE: begin
                if (item_reg.op == sst_pkg::OP_FRAME || dec_scan) begin
                    state_next = sst_pkg::ST_READ;
                end else begin
                    state_next = sst_pkg::ST_EMIT;
                end
            end
            sst_pkg::ST_READ: begin
                state_next = sst_pkg::ST_CHECK;
            end
            sst_pkg::ST_CHECK: begin
                if (item_reg.op == sst_pkg::OP_FRAME) begin
                    if (slot_live && pend_valid_reg && !can_push) begin
                        state_next = sst_pkg::ST_CHECK;
                    end else if (last_slot) begin
                        state_next = (slot_live || pend_valid_reg) ? sst_pkg::ST_FLUSH
                                                                   : sst_pkg::ST_IDLE;
                    end else begin
                        state_next = sst_pkg::ST_READ;
                    end
                end else if (slot_match || last_slot) begin
                    state_next = sst_pkg::ST_EMIT;
                end else begin
                    state_next = sst_pkg::ST_READ;
                end
            end
            sst_pkg::ST_FLUSH: begin
                if (can_push) begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            sst_pkg::ST_EMIT: begin
                if (can_push) begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            default: state_next = sst_pkg::ST_IDLE;
        endcase
    end

    // per-state outputs and datapath updates
    always_comb begin
        s_ready         = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        push            = 1'b0;
        push_data       = '0;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        verdict_next    = verdict_reg;
        reply_next      = reply_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_port_next  = pend_port_reg;
        frame_cnt_next  = frame_cnt_reg;
        case (state_reg)
            sst_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            sst_pkg::ST_DECODE: begin
                idx_next        = '0;
                free_found_next = 1'b0;
                pend_valid_next = 1'b0;
                verdict_next    = dec_verdict;
                reply_next      = dec_reply;
            end
            sst_pkg::ST_READ: begin
                rd_en = 1'b1;
            end
            sst_pkg::ST_CHECK: begin
                if (item_reg.op == sst_pkg::OP_FRAME) begin
                    // fan-out: hold one destination back so the final one can carry last
                    if (slot_live) begin
                        if (!pend_valid_reg || can_push) begin
                            push                   = pend_valid_reg;
                            push_data.result_kind  = sst_pkg::KIND_DEST;
                            push_data.dest_addr    = pend_addr_reg;
                            push_data.dest_port    = pend_port_reg;
                            push_data.frame_number = frame_cnt_reg;
                            pend_valid_next        = 1'b1;
                            pend_addr_next         = rd_data.addr;
                            pend_port_next         = rd_data.port;
                            if (!last_slot) begin
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end else if (!last_slot) begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end else if (slot_match) begin
                    // refresh the live matching slot
                    wr_en        = 1'b1;
                    wr_idx       = idx_reg;
                    verdict_next = sst_pkg::VERDICT_REFRESHED;
                end else begin
                    // remember the first dead slot, claim it after the walk
                    if (!slot_live && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (last_slot) begin
                        if (free_found_reg || !slot_live) begin
                            wr_en        = 1'b1;
                            wr_idx       = free_cand;
                            verdict_next = sst_pkg::VERDICT_NEW;
                        end else begin
                            verdict_next = sst_pkg::VERDICT_TABLE_FULL;
                        end
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            sst_pkg::ST_FLUSH: begin
                if (can_push) begin
                    push                   = 1'b1;
                    push_data.result_kind  = sst_pkg::KIND_DEST;
                    push_data.dest_addr    = pend_addr_reg;
                    push_data.dest_port    = pend_port_reg;
                    push_data.frame_number = frame_cnt_reg;
                    push_data.last         = 1'b1;
                    pend_valid_next        = 1'b0;
                    frame_cnt_next         = frame_cnt_reg + 64'd1;
                end
            end
            sst_pkg::ST_EMIT: begin
                if (can_push) begin
                    push                  = 1'b1;
                    push_data.result_kind = sst_pkg::KIND_VERDICT;
                    push_data.verdict     = verdict_reg;
                    push_data.sync_reply  = reply_reg;
                    push_data.echo_t1     = reply_reg ? item_reg.sync_t1 : 64'd0;
                    push_data.reply_time  = reply_reg ? item_reg.now_us : 64'd0;
                    push_data.last        = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sst_pkg::ST_IDLE;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            frame_cnt_reg  <= 64'd0;
            reply_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            pend_valid_reg <= pend_valid_next;
            frame_cnt_reg  <= frame_cnt_next;
            reply_reg      <= reply_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        free_idx_reg  <= free_idx_next;
        verdict_reg   <= verdict_next;
        pend_addr_reg <= pend_addr_next;
        pend_port_reg <= pend_port_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_data_reg <= push_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTH
    // a word is only loaded when the output register has room
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> can_push)
        else $error("result word pushed into a full output register");

    // a table write always ends the walk with a verdict
    a_write_then_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> state_reg == sst_pkg::ST_EMIT)
        else $error("slot write not followed by verdict");

    // the frame counter moves only with the final destination word of a frame
    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (frame_cnt_reg != $past(frame_cnt_reg))
        |-> $past(push && push_data.last && (push_data.result_kind == sst_pkg::KIND_DEST)))
        else $error("frame counter changed outside a final destination word");
`endif

endmodule
